// ----- rtl/ddwsl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ddwsl_pkg;

    localparam int FRAC_BITS = 16;

    localparam int CMD_W     = 32;
    localparam int LIM_W     = 31;
    localparam int TICK_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int OPND_W    = CMD_W + 1;
    localparam int PROD_W    = 2 * OPND_W;
    localparam int RAW_W     = 2 * CMD_W - FRAC_BITS;
    localparam int ALPHA_W   = FRAC_BITS + 1;
    localparam int STEP_W    = 5;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_HALF_BASE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_RADIUS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LINEAR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGULAR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WHEEL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_MAX_WHL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 3'd6;

    localparam logic [LIM_W-1:0]  RST_HALF_BASE   = 31'd22282;
    localparam logic [LIM_W-1:0]  RST_INV_RADIUS  = 31'd297891;
    localparam logic [LIM_W-1:0]  RST_MAX_LINEAR  = 31'd327680;
    localparam logic [LIM_W-1:0]  RST_MAX_ANGULAR = 31'd327680;
    localparam logic [LIM_W-1:0]  RST_MAX_WHEEL   = 31'd1489455;
    localparam logic [LIM_W-1:0]  RST_INV_MAX_WHL = 31'd2884;
    localparam logic [TICK_W-1:0] RST_TIMEOUT     = 16'd10;

    // datapath operations
    localparam logic [3:0] OP_NOP       = 4'd0;
    localparam logic [3:0] OP_CLAMP     = 4'd1;
    localparam logic [3:0] OP_MUL_TURN  = 4'd2;
    localparam logic [3:0] OP_TURN      = 4'd3;
    localparam logic [3:0] OP_LIN_L     = 4'd4;
    localparam logic [3:0] OP_LIN_R     = 4'd5;
    localparam logic [3:0] OP_MUL_WHEEL = 4'd6;
    localparam logic [3:0] OP_RAW_L     = 4'd7;
    localparam logic [3:0] OP_RAW_R     = 4'd8;
    localparam logic [3:0] OP_OVER_L    = 4'd9;
    localparam logic [3:0] OP_OVER_R    = 4'd10;
    localparam logic [3:0] OP_MUL_ALPHA = 4'd11;
    localparam logic [3:0] OP_ALPHA     = 4'd12;
    localparam logic [3:0] OP_REDUCE    = 4'd13;

    // sequencing kinds
    localparam logic [2:0] SEQ_NEXT      = 3'd0;
    localparam logic [2:0] SEQ_WAIT_IN   = 3'd1;
    localparam logic [2:0] SEQ_WAIT_OUT  = 3'd2;
    localparam logic [2:0] SEQ_JMP_PASS  = 3'd3;
    localparam logic [2:0] SEQ_JMP_ALPHA = 3'd4;
    localparam logic [2:0] SEQ_GOTO      = 3'd5;

    localparam logic [STEP_W-1:0] S_IDLE   = 5'd0;
    localparam logic [STEP_W-1:0] S_CLAMP  = 5'd1;
    localparam logic [STEP_W-1:0] S_LIN_L  = 5'd4;
    localparam logic [STEP_W-1:0] S_FINISH = 5'd17;

    typedef struct packed {
        logic [3:0]        op;
        logic [2:0]        seq;
        logic [STEP_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic pass;
        logic alpha_nz;
    } t_dp_status;

    typedef struct packed {
        logic [LIM_W-1:0] half_base;
        logic [LIM_W-1:0] inv_radius;
        logic [LIM_W-1:0] max_linear;
        logic [LIM_W-1:0] max_angular;
        logic [LIM_W-1:0] max_wheel;
        logic [LIM_W-1:0] inv_max_wheel;
    } t_cfg;

    // microprogram: one control word per step
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '{op: OP_NOP, seq: SEQ_NEXT, target: S_IDLE};
        case (step)
            5'd0:  w = '{op: OP_NOP,       seq: SEQ_WAIT_IN,   target: S_IDLE};
            5'd1:  w = '{op: OP_CLAMP,     seq: SEQ_NEXT,      target: S_IDLE};
            5'd2:  w = '{op: OP_MUL_TURN,  seq: SEQ_NEXT,      target: S_IDLE};
            5'd3:  w = '{op: OP_TURN,      seq: SEQ_NEXT,      target: S_IDLE};
            5'd4:  w = '{op: OP_LIN_L,     seq: SEQ_NEXT,      target: S_IDLE};
            5'd5:  w = '{op: OP_MUL_WHEEL, seq: SEQ_NEXT,      target: S_IDLE};
            5'd6:  w = '{op: OP_RAW_L,     seq: SEQ_NEXT,      target: S_IDLE};
            5'd7:  w = '{op: OP_LIN_R,     seq: SEQ_NEXT,      target: S_IDLE};
            5'd8:  w = '{op: OP_MUL_WHEEL, seq: SEQ_NEXT,      target: S_IDLE};
            5'd9:  w = '{op: OP_RAW_R,     seq: SEQ_JMP_PASS,  target: S_FINISH};
            5'd10: w = '{op: OP_OVER_L,    seq: SEQ_NEXT,      target: S_IDLE};
            5'd11: w = '{op: OP_MUL_ALPHA, seq: SEQ_NEXT,      target: S_IDLE};
            5'd12: w = '{op: OP_ALPHA,     seq: SEQ_NEXT,      target: S_IDLE};
            5'd13: w = '{op: OP_OVER_R,    seq: SEQ_NEXT,      target: S_IDLE};
            5'd14: w = '{op: OP_MUL_ALPHA, seq: SEQ_NEXT,      target: S_IDLE};
            5'd15: w = '{op: OP_ALPHA,     seq: SEQ_NEXT,      target: S_IDLE};
            5'd16: w = '{op: OP_REDUCE,    seq: SEQ_JMP_ALPHA, target: S_LIN_L};
            5'd17: w = '{op: OP_NOP,       seq: SEQ_WAIT_OUT,  target: S_IDLE};
            default: w = '{op: OP_NOP,     seq: SEQ_GOTO,      target: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ddwsl_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ddwsl_datapath (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire [3:0]                    i_op,
    input  ddwsl_pkg::t_cfg              i_cfg,
    input  wire [ddwsl_pkg::CMD_W-1:0]   i_held_lin,
    input  wire [ddwsl_pkg::CMD_W-1:0]   i_held_ang,
    output ddwsl_pkg::t_dp_status        o_status,
    output logic [ddwsl_pkg::CMD_W-1:0]  o_left,
    output logic [ddwsl_pkg::CMD_W-1:0]  o_right,
    output logic                         o_scaled
);

    localparam int CW = ddwsl_pkg::CMD_W;
    localparam int LW = ddwsl_pkg::LIM_W;
    localparam int RW = ddwsl_pkg::RAW_W;
    localparam int PW = ddwsl_pkg::PROD_W;
    localparam int OW = ddwsl_pkg::OPND_W;
    localparam int AW = ddwsl_pkg::ALPHA_W;
    localparam int FB = ddwsl_pkg::FRAC_BITS;
    localparam logic [AW-1:0] ALPHA_ONE = AW'(1) << FB;

    logic signed [CW-1:0] r_v;
    logic signed [CW-1:0] r_w;
    logic signed [CW-1:0] r_lin;
    logic signed [RW-1:0] r_turn;
    logic signed [RW-1:0] r_lraw;
    logic signed [RW-1:0] r_rraw;
    logic signed [PW-1:0] r_prod;
    logic [CW-1:0]        r_over;
    logic                 r_big;
    logic                 r_small;
    logic [AW-1:0]        r_alpha;
    logic                 r_pass;
    logic                 r_scaled;

    function automatic logic [CW-1:0] clamp_cmd(input logic [CW-1:0] x,
                                                 input logic [LW-1:0] lim);
        logic signed [CW:0] xs;
        logic signed [CW:0] ls;
        logic [CW-1:0]      res;
        xs = {x[CW-1], x};
        ls = {{(CW+1-LW){1'b0}}, lim};
        if (xs > ls)       res = CW'(ls);
        else if (xs < -ls) res = CW'(-ls);
        else               res = x;
        return res;
    endfunction

    function automatic logic [CW-1:0] sat_cmd(input logic signed [RW:0] x);
        logic [CW-1:0] res;
        if (x[RW:CW-1] == {(RW-CW+2){1'b0}} || x[RW:CW-1] == {(RW-CW+2){1'b1}})
            res = x[CW-1:0];
        else if (x[RW])
            res = {1'b1, {(CW-1){1'b0}}};
        else
            res = {1'b0, {(CW-1){1'b1}}};
        return res;
    endfunction

    function automatic logic [CW-1:0] clamp_raw(input logic signed [RW-1:0] x,
                                                 input logic [LW-1:0] lim);
        logic signed [RW-1:0] ls;
        logic [CW-1:0]        res;
        ls = {{(RW-LW){1'b0}}, lim};
        if (x > ls)       res = CW'(ls);
        else if (x < -ls) res = CW'(-ls);
        else              res = x[CW-1:0];
        return res;
    endfunction

    // shared multiplier operands
    logic signed [OW-1:0] mul_a;
    logic signed [OW-1:0] mul_b;
    logic signed [RW:0]   lin_sum;
    logic signed [RW-1:0] raw_sel;
    logic [RW-1:0]        raw_mag;
    logic [RW-1:0]        over_full;
    logic [AW-1:0]        alpha_new;
    logic [CW-1:0]        alpha_ext;

    always_comb begin
        case (i_op)
            ddwsl_pkg::OP_MUL_TURN: begin
                mul_a = {r_w[CW-1], r_w};
                mul_b = {{(OW-LW){1'b0}}, i_cfg.half_base};
            end
            ddwsl_pkg::OP_MUL_WHEEL: begin
                mul_a = {r_lin[CW-1], r_lin};
                mul_b = {{(OW-LW){1'b0}}, i_cfg.inv_radius};
            end
            default: begin
                mul_a = {1'b0, r_over};
                mul_b = {{(OW-LW){1'b0}}, i_cfg.inv_max_wheel};
            end
        endcase
    end

    always_comb begin
        if (i_op == ddwsl_pkg::OP_LIN_R)
            lin_sum = {{(RW+1-CW){r_v[CW-1]}}, r_v} + {r_turn[RW-1], r_turn};
        else
            lin_sum = {{(RW+1-CW){r_v[CW-1]}}, r_v} - {r_turn[RW-1], r_turn};

        raw_sel   = (i_op == ddwsl_pkg::OP_OVER_R) ? r_rraw : r_lraw;
        raw_mag   = raw_sel[RW-1] ? RW'(-raw_sel) : RW'(raw_sel);
        over_full = raw_mag - {{(RW-LW){1'b0}}, i_cfg.max_wheel};

        // over * inv_max >= 1.0 in Q(2F) saturates alpha at one
        if (r_small)
            alpha_new = '0;
        else if (r_big || r_prod[PW-1:2*FB] != '0)
            alpha_new = ALPHA_ONE;
        else
            alpha_new = {1'b0, r_prod[2*FB-1:FB]};

        alpha_ext = {{(CW-AW){1'b0}}, r_alpha};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass   <= 1'b0;
            r_scaled <= 1'b0;
            r_alpha  <= '0;
        end else begin
            case (i_op)
                ddwsl_pkg::OP_CLAMP: begin
                    r_v      <= clamp_cmd(i_held_lin, i_cfg.max_linear);
                    r_w      <= clamp_cmd(i_held_ang, i_cfg.max_angular);
                    r_alpha  <= '0;
                    r_pass   <= 1'b0;
                    r_scaled <= 1'b0;
                end
                ddwsl_pkg::OP_MUL_TURN, ddwsl_pkg::OP_MUL_WHEEL,
                ddwsl_pkg::OP_MUL_ALPHA: begin
                    r_prod <= mul_a * mul_b;
                end
                ddwsl_pkg::OP_TURN:  r_turn <= r_prod[RW+FB-1:FB];
                ddwsl_pkg::OP_LIN_L,
                ddwsl_pkg::OP_LIN_R: r_lin  <= sat_cmd(lin_sum);
                ddwsl_pkg::OP_RAW_L: r_lraw <= r_prod[RW+FB-1:FB];
                ddwsl_pkg::OP_RAW_R: r_rraw <= r_prod[RW+FB-1:FB];
                ddwsl_pkg::OP_OVER_L, ddwsl_pkg::OP_OVER_R: begin
                    r_small <= (raw_mag <= {{(RW-LW){1'b0}}, i_cfg.max_wheel})
                               || (i_cfg.inv_max_wheel == '0);
                    r_big   <= (over_full[RW-1:CW] != '0);
                    r_over  <= over_full[CW-1:0];
                end
                ddwsl_pkg::OP_ALPHA: begin
                    if (alpha_new > r_alpha) r_alpha <= alpha_new;
                end
                ddwsl_pkg::OP_REDUCE: begin
                    if (r_alpha != '0) begin
                        r_v      <= r_v[CW-1] ? r_v + alpha_ext : r_v - alpha_ext;
                        r_pass   <= 1'b1;
                        r_scaled <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_status.pass     = r_pass;
    assign o_status.alpha_nz = (r_alpha != '0);
    assign o_left            = clamp_raw(r_lraw, i_cfg.max_wheel);
    assign o_right           = clamp_raw(r_rraw, i_cfg.max_wheel);
    assign o_scaled          = r_scaled;

endmodule

`default_nettype wire

// ----- rtl/diff_drive_wheel_speed_limiter.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                      payload
// s_axis    in         i_s_axis_tvalid/o_s_axis_tready tdata, tuser: control tick
// m_axis    out        o_m_axis_tvalid/i_m_axis_tready tdata, tuser: wheel speeds
// cfg       in         i_cfg_we                        i_cfg_addr, i_cfg_wdata
//
// when the alpha reduction is needed, the program reruns the wheel path before
// the result; a new input beat is taken only at the idle step, so ticks do not
// overlap. one shared 33x33 multiplier is used for every product.
// synchronous active-low reset restores the register defaults and clears the
// held command and the command age. a result waiting on m_axis does not block
// the next beat; the program stalls at its last step until that result is taken.

module diff_drive_wheel_speed_limiter (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // [31:0] linear_command, [63:32] angular_command
    input  wire [2*ddwsl_pkg::CMD_W-1:0]         i_s_axis_tdata,
    // [0] operation
    input  wire                                  i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  wire                                  i_m_axis_tready,
    // [31:0] left speed, [63:32] right speed
    output logic [2*ddwsl_pkg::CMD_W-1:0]        o_m_axis_tdata,
    // [0] timed_out, [1] scaled_down
    output logic [1:0]                           o_m_axis_tuser,
    input  wire                                  i_cfg_we,
    input  wire [ddwsl_pkg::CFG_IDX_W-1:0]       i_cfg_addr,
    input  wire [ddwsl_pkg::LIM_W-1:0]           i_cfg_wdata
);

    localparam int CW = ddwsl_pkg::CMD_W;
    localparam int TW = ddwsl_pkg::TICK_W;
    localparam int SW = ddwsl_pkg::STEP_W;

    ddwsl_pkg::t_cfg       r_cfg;
    logic [TW-1:0]         r_timeout;
    logic [CW-1:0]         r_held_lin;
    logic [CW-1:0]         r_held_ang;
    logic [TW-1:0]         r_age;
    logic                  r_stale;
    logic [SW-1:0]         r_step;
    logic [SW-1:0]         n_step;
    logic                  r_out_valid;
    logic [2*CW-1:0]       r_out_data;
    logic [1:0]            r_out_user;

    ddwsl_pkg::t_uword     uw;
    ddwsl_pkg::t_dp_status dp_status;
    logic [CW-1:0]         left;
    logic [CW-1:0]         right;
    logic                  scaled;
    logic                  s_beat;
    logic                  out_free;
    logic [TW-1:0]         age_eff;

    assign uw              = ddwsl_pkg::ucode(r_step);
    assign o_s_axis_tready = (uw.seq == ddwsl_pkg::SEQ_WAIT_IN);
    assign s_beat          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign age_eff         = i_s_axis_tuser ? '0 : r_age;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_base     <= ddwsl_pkg::RST_HALF_BASE;
            r_cfg.inv_radius    <= ddwsl_pkg::RST_INV_RADIUS;
            r_cfg.max_linear    <= ddwsl_pkg::RST_MAX_LINEAR;
            r_cfg.max_angular   <= ddwsl_pkg::RST_MAX_ANGULAR;
            r_cfg.max_wheel     <= ddwsl_pkg::RST_MAX_WHEEL;
            r_cfg.inv_max_wheel <= ddwsl_pkg::RST_INV_MAX_WHL;
            r_timeout           <= ddwsl_pkg::RST_TIMEOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                ddwsl_pkg::REG_HALF_BASE:   r_cfg.half_base     <= i_cfg_wdata;
                ddwsl_pkg::REG_INV_RADIUS:  r_cfg.inv_radius    <= i_cfg_wdata;
                ddwsl_pkg::REG_MAX_LINEAR:  r_cfg.max_linear    <= i_cfg_wdata;
                ddwsl_pkg::REG_MAX_ANGULAR: r_cfg.max_angular   <= i_cfg_wdata;
                ddwsl_pkg::REG_MAX_WHEEL:   r_cfg.max_wheel     <= i_cfg_wdata;
                ddwsl_pkg::REG_INV_MAX_WHL: r_cfg.inv_max_wheel <= i_cfg_wdata;
                ddwsl_pkg::REG_TIMEOUT:     r_timeout           <= i_cfg_wdata[TW-1:0];
                default: begin
                end
            endcase
        end
    end

    // tick bookkeeping happens on the input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_lin <= '0;
            r_held_ang <= '0;
            r_age      <= '0;
            r_stale    <= 1'b0;
        end else if (s_beat) begin
            if (i_s_axis_tuser) begin
                r_held_lin <= i_s_axis_tdata[CW-1:0];
                r_held_ang <= i_s_axis_tdata[2*CW-1:CW];
            end
            r_stale <= (age_eff > r_timeout);
            r_age   <= (age_eff != {TW{1'b1}}) ? age_eff + 1'b1 : age_eff;
        end
    end

    always_comb begin
        case (uw.seq)
            ddwsl_pkg::SEQ_NEXT:      n_step = SW'(r_step + 1'b1);
            ddwsl_pkg::SEQ_WAIT_IN:   n_step = s_beat ? SW'(r_step + 1'b1) : r_step;
            ddwsl_pkg::SEQ_WAIT_OUT:  n_step = out_free ? uw.target : r_step;
            ddwsl_pkg::SEQ_JMP_PASS:  n_step = dp_status.pass ? uw.target
                                                              : SW'(r_step + 1'b1);
            ddwsl_pkg::SEQ_JMP_ALPHA: n_step = dp_status.alpha_nz ? uw.target
                                                                  : SW'(r_step + 1'b1);
            default:                  n_step = uw.target;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_step <= ddwsl_pkg::S_IDLE;
        else          r_step <= n_step;
    end

    ddwsl_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (uw.op),
        .i_cfg      (r_cfg),
        .i_held_lin (r_held_lin),
        .i_held_ang (r_held_ang),
        .o_status   (dp_status),
        .o_left     (left),
        .o_right    (right),
        .o_scaled   (scaled)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (uw.seq == ddwsl_pkg::SEQ_WAIT_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.seq == ddwsl_pkg::SEQ_WAIT_OUT && out_free) begin
            r_out_data <= r_stale ? '0 : {right, left};
            r_out_user <= {scaled && !r_stale, r_stale};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    a_stale_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |->
            o_m_axis_tdata == '0 && !o_m_axis_tuser[1])
        else $error("stale result carries nonzero speed or scale flag");

    a_beat_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_beat |=> r_step == ddwsl_pkg::S_CLAMP)
        else $error("program did not start after input beat");

    a_latch_age: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_beat && i_s_axis_tuser |=> r_age == TW'(1))
        else $error("command age not restarted by latch");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_step) == ddwsl_pkg::S_FINISH)
        else $error("result raised outside the final step");

endmodule

`default_nettype wire
